// ===== design/schit_pkg.sv =====
// ----------------------------------------------------------------------------
// schit_pkg
// Shared types and constants for the segment/circle hit test pipeline.
// ----------------------------------------------------------------------------
package schit_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 1;
    localparam int D_W         = 17;
    localparam int R_W         = 15;
    localparam int LEN2_W      = 34;
    localparam int NUM_W       = 35;

    typedef enum logic [1:0] {
        TSEL_ZERO,
        TSEL_ONE,
        TSEL_DIV
    } t_tsel;

    typedef struct packed {
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic signed [D_W-1:0] ox;
        logic signed [D_W-1:0] oy;
        logic [R_W-1:0]        r;
        logic                  zero_len;
        t_tsel                 tsel;
    } t_geo;

    typedef struct packed {
        t_geo                   geo;
        logic [LEN2_W-1:0]      len2;
        logic [LEN2_W-1:0]      rem;
        logic [T_FRAC_BITS-1:0] q;
    } t_div;

endpackage

// ===== design/schit_div_step.sv =====
// ----------------------------------------------------------------------------
// schit_div_step
// One restoring-division stage: one quotient bit per beat, registered.
// ----------------------------------------------------------------------------
module schit_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  schit_pkg::t_div i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output schit_pkg::t_div o_data
);
    import schit_pkg::*;

    logic              r_v;
    t_div              r_d;
    t_div              n_d;
    logic [LEN2_W:0]   w_rem2;
    logic [LEN2_W:0]   w_diff;
    logic              w_bit;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        w_rem2 = {i_data.rem, 1'b0};
        w_diff = w_rem2 - {1'b0, i_data.len2};
        w_bit  = (w_rem2 >= {1'b0, i_data.len2});
        n_d     = i_data;
        n_d.rem = w_bit ? w_diff[LEN2_W-1:0] : w_rem2[LEN2_W-1:0];
        n_d.q   = {i_data.q[T_FRAC_BITS-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d <= n_d;
        end
    end

endmodule

// ===== design/segment_circle_hit_test.sv =====
// ----------------------------------------------------------------------------
// segment_circle_hit_test
// Pipelined segment versus circle intersection test, one test per beat.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one
// hit flag per beat, in order. Three stages form the differences, products
// and the squared length / projection numerator, T_FRAC_BITS stages each
// produce one bit of the projection parameter by restoring division, and
// five stages form the nearest point, the squared distance and the compare.
// Every stage has its own valid bit and a stall only holds stages that are
// full, so bubbles are squeezed out.
module segment_circle_hit_test (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, circle_x, circle_y
    // (16 each), circle_radius (15), one zero pad bit
    input  logic [111:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit (1), seven zero pad bits
    output logic [7:0]   o_m_tdata
);
    import schit_pkg::*;

    localparam int P_W  = 2 * D_W;
    localparam int PT_W = T_W + D_W + 1;
    localparam int F_W  = PT_W - T_FRAC_BITS;
    localparam int DD_W = F_W + 1;
    localparam int SQ_W = 2 * DD_W;

    // stage A: differences
    logic                  r_a_v;
    t_geo                  r_a;
    logic                  w_a_rdy;
    logic signed [D_W-1:0] w_sx, w_sy, w_ex, w_ey, w_cx, w_cy;

    // stage B: products
    logic                  r_b_v;
    t_geo                  r_b;
    logic signed [P_W-1:0] r_b_xx, r_b_yy, r_b_nx, r_b_ny;
    logic                  w_b_rdy;

    // stage C: len2, numerator, clamp decision
    logic                  r_c_v;
    t_div                  r_c;
    t_div                  n_c;
    logic                  w_c_rdy;
    logic [LEN2_W:0]       w_len2;
    logic signed [NUM_W-1:0] w_num;

    // divider chain
    logic                  w_dv   [0:T_FRAC_BITS];
    logic                  w_drdy [0:T_FRAC_BITS];
    t_div                  w_dd   [0:T_FRAC_BITS];

    // stage D: t
    logic                  r_d_v;
    t_geo                  r_d;
    logic [T_W-1:0]        r_d_t;
    logic [T_W-1:0]        n_d_t;
    logic                  w_d_rdy;

    // stage E: t * d
    logic                  r_e_v;
    t_geo                  r_e;
    logic signed [PT_W-1:0] r_e_px, r_e_py;
    logic                  w_e_rdy;

    // stage F: centre minus nearest point
    logic                  r_f_v;
    t_geo                  r_f;
    logic signed [DD_W-1:0] r_f_ddx, r_f_ddy;
    logic                  w_f_rdy;
    logic signed [PT_W-1:0] w_fx, w_fy;

    // stage G: squares
    logic                  r_g_v;
    logic                  r_g_zero;
    logic [SQ_W-1:0]       r_g_sx, r_g_sy;
    logic [2*R_W-1:0]      r_g_r2;
    logic                  w_g_rdy;

    // stage H: output
    logic                  r_h_v;
    logic                  r_h_hit;
    logic                  w_h_rdy;

    // ------------------------------------------------------------------ A
    assign w_a_rdy    = !r_a_v || w_b_rdy;
    assign o_s_tready = w_a_rdy;

    assign w_sx = D_W'($signed(i_s_tdata[15:0]));
    assign w_sy = D_W'($signed(i_s_tdata[31:16]));
    assign w_ex = D_W'($signed(i_s_tdata[47:32]));
    assign w_ey = D_W'($signed(i_s_tdata[63:48]));
    assign w_cx = D_W'($signed(i_s_tdata[79:64]));
    assign w_cy = D_W'($signed(i_s_tdata[95:80]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_a_rdy) begin
            r_a_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy && i_s_tvalid) begin
            r_a.dx       <= w_ex - w_sx;
            r_a.dy       <= w_ey - w_sy;
            r_a.ox       <= w_cx - w_sx;
            r_a.oy       <= w_cy - w_sy;
            r_a.r        <= i_s_tdata[110:96];
            r_a.zero_len <= 1'b0;
            r_a.tsel     <= TSEL_ZERO;
        end
    end

    // ------------------------------------------------------------------ B
    assign w_b_rdy = !r_b_v || w_c_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_b_rdy) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_rdy && r_a_v) begin
            r_b    <= r_a;
            r_b_xx <= r_a.dx * r_a.dx;
            r_b_yy <= r_a.dy * r_a.dy;
            r_b_nx <= r_a.ox * r_a.dx;
            r_b_ny <= r_a.oy * r_a.dy;
        end
    end

    // ------------------------------------------------------------------ C
    assign w_c_rdy = !r_c_v || w_drdy[0];

    always_comb begin
        w_len2 = {1'b0, r_b_xx[LEN2_W-1:0]} + {1'b0, r_b_yy[LEN2_W-1:0]};
        w_num  = NUM_W'(r_b_nx) + NUM_W'(r_b_ny);
        n_c          = '0;
        n_c.geo      = r_b;
        n_c.len2     = w_len2[LEN2_W-1:0];
        n_c.rem      = w_num[LEN2_W-1:0];
        n_c.q        = '0;
        n_c.geo.zero_len = (w_len2 == '0);
        if (w_num <= 0) begin
            n_c.geo.tsel = TSEL_ZERO;
        end else if ($signed({1'b0, w_len2[LEN2_W-1:0]}) <= w_num) begin
            n_c.geo.tsel = TSEL_ONE;
        end else begin
            n_c.geo.tsel = TSEL_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_c_rdy) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_rdy && r_b_v) begin
            r_c <= n_c;
        end
    end

    // ------------------------------------------------------------ divider
    assign w_dv[0] = r_c_v;
    assign w_dd[0] = r_c;

    for (genvar g = 0; g < T_FRAC_BITS; g++) begin : g_div
        schit_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[g]),
            .o_ready (w_drdy[g]),
            .i_data  (w_dd[g]),
            .o_valid (w_dv[g+1]),
            .i_ready (w_drdy[g+1]),
            .o_data  (w_dd[g+1])
        );
    end

    assign w_drdy[T_FRAC_BITS] = w_d_rdy;

    // ------------------------------------------------------------------ D
    assign w_d_rdy = !r_d_v || w_e_rdy;

    always_comb begin
        case (w_dd[T_FRAC_BITS].geo.tsel)
            TSEL_ZERO: n_d_t = '0;
            TSEL_ONE:  n_d_t = {1'b1, {T_FRAC_BITS{1'b0}}};
            TSEL_DIV:  n_d_t = {1'b0, w_dd[T_FRAC_BITS].q};
            default:   n_d_t = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_d_rdy) begin
            r_d_v <= w_dv[T_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_rdy && w_dv[T_FRAC_BITS]) begin
            r_d   <= w_dd[T_FRAC_BITS].geo;
            r_d_t <= n_d_t;
        end
    end

    // ------------------------------------------------------------------ E
    assign w_e_rdy = !r_e_v || w_f_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_e_rdy) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_rdy && r_d_v) begin
            r_e    <= r_d;
            r_e_px <= $signed({1'b0, r_d_t}) * PT_W'(r_d.dx);
            r_e_py <= $signed({1'b0, r_d_t}) * PT_W'(r_d.dy);
        end
    end

    // ------------------------------------------------------------------ F
    assign w_f_rdy = !r_f_v || w_g_rdy;
    assign w_fx    = r_e_px >>> T_FRAC_BITS;
    assign w_fy    = r_e_py >>> T_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_f_rdy) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_rdy && r_e_v) begin
            r_f     <= r_e;
            r_f_ddx <= DD_W'(r_e.ox) - DD_W'($signed(w_fx[F_W-1:0]));
            r_f_ddy <= DD_W'(r_e.oy) - DD_W'($signed(w_fy[F_W-1:0]));
        end
    end

    // ------------------------------------------------------------------ G
    assign w_g_rdy = !r_g_v || w_h_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_g_rdy) begin
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_g_rdy && r_f_v) begin
            r_g_zero <= r_f.zero_len;
            r_g_sx   <= SQ_W'(r_f_ddx) * SQ_W'(r_f_ddx);
            r_g_sy   <= SQ_W'(r_f_ddy) * SQ_W'(r_f_ddy);
            r_g_r2   <= r_f.r * r_f.r;
        end
    end

    // ------------------------------------------------------------------ H
    assign w_h_rdy = !r_h_v || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (w_h_rdy) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_h_rdy && r_g_v) begin
            r_h_hit <= !r_g_zero &&
                       (({1'b0, r_g_sx} + {1'b0, r_g_sy}) <= (SQ_W + 1)'(r_g_r2));
        end
    end

    assign o_m_tvalid = r_h_v;
    assign o_m_tdata  = {7'b0, r_h_hit};

endmodule
